>>> hw/rtl/met_pkg.sv
package met_pkg;

  localparam logic [1:0] StatusOk         = 2'd0;
  localparam logic [1:0] StatusFull       = 2'd1;
  localparam logic [1:0] StatusNotShared  = 2'd2;
  localparam logic [1:0] StatusDegenerate = 2'd3;

  localparam logic KindAdd   = 1'b0;
  localparam logic KindQuery = 1'b1;

  localparam int unsigned ShareW = 2;
  localparam logic [ShareW-1:0] ShareNone = 2'd0;
  localparam logic [ShareW-1:0] ShareOne  = 2'd1;
  localparam logic [ShareW-1:0] ShareTwo  = 2'd2;

endpackage

>>> hw/rtl/mesh_edge_table_and_adjacent_pairs.sv
// Add item: the key memory is scanned entry by entry, then each edge of the triangle takes a
// read-modify-write. A table-full add stops after the scan. Query item: an owner read, then two
// vertex reads. One item is in work at a time; a finished result waits in the output register
// while the next item is accepted. Reset (asynchronous, active low) clears the edge and
// triangle counts; the memories are not cleared and their data is only used after being written.
module mesh_edge_table_and_adjacent_pairs #(
  parameter int MAX_TRIANGLES = 1024,
  parameter int MAX_EDGES     = 4096,
  parameter int VERTEX_BITS   = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic [VERTEX_BITS-1:0]           vert_a_i,
  input  logic [VERTEX_BITS-1:0]           vert_b_i,
  input  logic [VERTEX_BITS-1:0]           vert_c_i,
  input  logic [$clog2(MAX_EDGES)-1:0]     query_edge_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [$clog2(MAX_EDGES)-1:0]     edge_first_o,
  output logic [$clog2(MAX_EDGES)-1:0]     edge_second_o,
  output logic [$clog2(MAX_EDGES)-1:0]     edge_third_o,
  output logic [2:0]                       new_edge_flags_o,
  output logic [$clog2(MAX_EDGES+1)-1:0]   edge_total_o,
  output logic [VERTEX_BITS-1:0]           unshared_first_o,
  output logic [VERTEX_BITS-1:0]           unshared_second_o,
  output logic [VERTEX_BITS-1:0]           shared_first_o,
  output logic [VERTEX_BITS-1:0]           shared_second_o,
  output logic [$clog2(MAX_TRIANGLES)-1:0] tri_first_o,
  output logic [$clog2(MAX_TRIANGLES)-1:0] tri_second_o
);

  localparam int VB = VERTEX_BITS;
  localparam int KW = 2 * VB;
  localparam int EB = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int TB = $clog2(MAX_TRIANGLES);
  localparam int TW = $clog2(MAX_TRIANGLES + 1);
  localparam int OW = met_pkg::ShareW + 2 * TB;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_ASSIGN = 4'd2;
  localparam logic [3:0] S_KEYW   = 4'd3;
  localparam logic [3:0] S_ORD    = 4'd4;
  localparam logic [3:0] S_OMW    = 4'd5;
  localparam logic [3:0] S_QOWN   = 4'd6;
  localparam logic [3:0] S_QCHK   = 4'd7;
  localparam logic [3:0] S_QT1    = 4'd8;
  localparam logic [3:0] S_QT2    = 4'd9;
  localparam logic [3:0] S_QEND   = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  typedef struct packed {
    logic [1:0]    status;
    logic [EB-1:0] e0;
    logic [EB-1:0] e1;
    logic [EB-1:0] e2;
    logic [2:0]    flags;
    logic [VB-1:0] uf;
    logic [VB-1:0] us;
    logic [VB-1:0] sf;
    logic [VB-1:0] ss;
    logic [TB-1:0] t1;
    logic [TB-1:0] t2;
  } res_t;

  logic [3:0]    state_q;
  logic [CW-1:0] edge_cnt_q;
  logic [TW-1:0] tri_cnt_q;
  logic [KW-1:0] k_q [3];
  logic [VB-1:0] v_q [3];
  logic [CW-1:0] scan_q;
  logic          pend_q;
  logic [EB-1:0] pidx_q;
  logic [2:0]    found_q;
  logic [EB-1:0] fidx_q [3];
  logic [EB-1:0] idx_q [3];
  logic [2:0]    new_q;
  logic [1:0]    e_q;
  logic [EB-1:0] qe_q;
  logic [VB-1:0] p1_q [3];
  logic [VB-1:0] p2_q [3];
  res_t          res_q;
  res_t          out_q;
  logic          out_valid_q;
  logic [CW-1:0] out_total_q;

  // Memory ports.
  logic          key_we;
  logic [EB-1:0] key_waddr;
  logic [EB-1:0] key_raddr;
  logic [KW-1:0] key_rdata;
  logic          own_we;
  logic [EB-1:0] own_addr;
  logic [OW-1:0] own_wdata;
  logic [OW-1:0] own_rdata;
  logic          tri_we;
  logic [TB-1:0] tri_raddr;
  logic [3*VB-1:0] tri_rdata;

  logic          quad_ok;
  logic [VB-1:0] q_uf, q_us, q_sf, q_ss;

  met_ram #(.Width(KW), .Depth(MAX_EDGES)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(key_waddr), .wdata_i(k_q[e_q]),
    .raddr_i(key_raddr), .rdata_o(key_rdata)
  );

  met_ram #(.Width(OW), .Depth(MAX_EDGES)) u_own_ram (
    .clk_i, .we_i(own_we), .waddr_i(own_addr), .wdata_i(own_wdata),
    .raddr_i(own_addr), .rdata_o(own_rdata)
  );

  met_ram #(.Width(3*VB), .Depth(MAX_TRIANGLES)) u_tri_ram (
    .clk_i, .we_i(tri_we), .waddr_i(tri_cnt_q[TB-1:0]),
    .wdata_i({v_q[2], v_q[1], v_q[0]}), .raddr_i(tri_raddr), .rdata_o(tri_rdata)
  );

  met_quad #(.VB(VB)) u_quad (
    .p1_i(p1_q), .p2_i(p2_q), .ok_o(quad_ok),
    .unshared_first_o(q_uf), .unshared_second_o(q_us),
    .shared_first_o(q_sf), .shared_second_o(q_ss)
  );

  // Keys are (min, max) of each vertex pair in triangle order.
  logic [VB-1:0] va [3];
  logic [KW-1:0] kin [3];
  always_comb begin
    va[0] = vert_a_i;
    va[1] = vert_b_i;
    va[2] = vert_c_i;
    for (int e = 0; e < 3; e++) begin
      if (va[e] < va[(e + 1) % 3]) kin[e] = {va[e], va[(e + 1) % 3]};
      else kin[e] = {va[(e + 1) % 3], va[e]};
    end
  end

  // Index assignment for the triangle's edges after the scan is complete.
  logic          dup1, dup20, dup21;
  logic [2:0]    new_d;
  logic [EB-1:0] idx_d [3];
  logic [1:0]    needed;
  logic          full;
  always_comb begin
    dup1  = k_q[1] == k_q[0];
    dup20 = k_q[2] == k_q[0];
    dup21 = k_q[2] == k_q[1];
    new_d[0] = !found_q[0];
    new_d[1] = !found_q[1] && !dup1;
    new_d[2] = !found_q[2] && !dup20 && !dup21;
    needed = 2'(new_d[0]) + 2'(new_d[1]) + 2'(new_d[2]);
    full = (tri_cnt_q >= TW'(MAX_TRIANGLES)) ||
           (({1'b0, edge_cnt_q} + (CW+1)'(needed)) > (CW+1)'(MAX_EDGES));
    idx_d[0] = found_q[0] ? fidx_q[0] : edge_cnt_q[EB-1:0];
    if (found_q[1]) idx_d[1] = fidx_q[1];
    else if (dup1) idx_d[1] = idx_d[0];
    else idx_d[1] = EB'(edge_cnt_q + CW'(new_d[0]));
    if (found_q[2]) idx_d[2] = fidx_q[2];
    else if (dup20) idx_d[2] = idx_d[0];
    else if (dup21) idx_d[2] = idx_d[1];
    else idx_d[2] = EB'(edge_cnt_q + CW'(new_d[0]) + CW'(new_d[1]));
  end

  // Owner entry update: an edge stored by this triangle starts with no sharer.
  logic [met_pkg::ShareW-1:0] share;
  logic [TB-1:0]              own1, own2;
  always_comb begin
    own1  = own_rdata[2*TB-1:TB];
    own2  = own_rdata[TB-1:0];
    share = new_q[e_q] ? met_pkg::ShareNone : own_rdata[OW-1:2*TB];
    own_wdata = own_rdata;
    case (share)
      met_pkg::ShareNone: own_wdata = {met_pkg::ShareOne, tri_cnt_q[TB-1:0], own2};
      met_pkg::ShareOne:  own_wdata = {met_pkg::ShareTwo, own1, tri_cnt_q[TB-1:0]};
      default:            own_wdata = own_rdata;
    endcase
  end

  assign key_raddr = scan_q[EB-1:0];
  assign key_we    = (state_q == S_KEYW) && new_q[e_q];
  assign key_waddr = idx_q[e_q];
  assign own_addr  = (state_q == S_QOWN) ? qe_q : idx_q[e_q];
  assign own_we    = state_q == S_OMW;
  assign tri_we    = (state_q == S_ASSIGN) && !full;
  assign tri_raddr = (state_q == S_QCHK) ? own1 : res_q.t2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      edge_cnt_q  <= '0;
      tri_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      e_q         <= '0;
    end else begin
      // The hand-over state sets the flag itself when it loads a new result.
      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            res_q   <= '0;
            scan_q  <= '0;
            pend_q  <= 1'b0;
            found_q <= '0;
            e_q     <= '0;
            qe_q    <= query_edge_i;
            for (int e = 0; e < 3; e++) begin
              k_q[e] <= kin[e];
              v_q[e] <= va[e];
            end
            state_q <= (kind_i == met_pkg::KindQuery) ? S_QOWN : S_SCAN;
          end
        end
        S_SCAN: begin
          // One key read is issued per cycle; its data is compared in the cycle after.
          if (pend_q) begin
            for (int e = 0; e < 3; e++) begin
              if (!found_q[e] && key_rdata == k_q[e]) begin
                found_q[e] <= 1'b1;
                fidx_q[e]  <= pidx_q;
              end
            end
          end
          if (scan_q < edge_cnt_q) begin
            pend_q <= 1'b1;
            pidx_q <= scan_q[EB-1:0];
            scan_q <= scan_q + 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) state_q <= S_ASSIGN;
          end
        end
        S_ASSIGN: begin
          if (full) begin
            res_q.status <= met_pkg::StatusFull;
            state_q      <= S_DONE;
          end else begin
            for (int e = 0; e < 3; e++) idx_q[e] <= idx_d[e];
            new_q      <= new_d;
            edge_cnt_q <= edge_cnt_q + CW'(needed);
            state_q    <= S_KEYW;
          end
        end
        S_KEYW: begin
          if (e_q == 2'd2) begin
            e_q     <= '0;
            state_q <= S_ORD;
          end else begin
            e_q <= e_q + 1'b1;
          end
        end
        S_ORD: state_q <= S_OMW;
        S_OMW: begin
          if (e_q == 2'd2) begin
            tri_cnt_q    <= tri_cnt_q + 1'b1;
            res_q.status <= met_pkg::StatusOk;
            res_q.e0     <= idx_q[0];
            res_q.e1     <= idx_q[1];
            res_q.e2     <= idx_q[2];
            res_q.flags  <= new_q;
            state_q      <= S_DONE;
          end else begin
            e_q     <= e_q + 1'b1;
            state_q <= S_ORD;
          end
        end
        S_QOWN: begin
          if ({1'b0, qe_q} >= edge_cnt_q) begin
            res_q.status <= met_pkg::StatusNotShared;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_QCHK;
          end
        end
        S_QCHK: begin
          if (own_rdata[OW-1:2*TB] < met_pkg::ShareTwo) begin
            res_q.status <= met_pkg::StatusNotShared;
            state_q      <= S_DONE;
          end else begin
            res_q.t1 <= own1;
            res_q.t2 <= own2;
            state_q  <= S_QT1;
          end
        end
        S_QT1: begin
          for (int e = 0; e < 3; e++) p1_q[e] <= tri_rdata[e*VB +: VB];
          state_q <= S_QT2;
        end
        S_QT2: begin
          for (int e = 0; e < 3; e++) p2_q[e] <= tri_rdata[e*VB +: VB];
          state_q <= S_QEND;
        end
        S_QEND: begin
          if (quad_ok) begin
            res_q.status <= met_pkg::StatusOk;
            res_q.uf     <= q_uf;
            res_q.us     <= q_us;
            res_q.sf     <= q_sf;
            res_q.ss     <= q_ss;
          end else begin
            res_q.status <= met_pkg::StatusDegenerate;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Hand over once the output register is free or being emptied.
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_total_q <= edge_cnt_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o        = state_q != S_IDLE;
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign edge_first_o      = out_q.e0;
  assign edge_second_o     = out_q.e1;
  assign edge_third_o      = out_q.e2;
  assign new_edge_flags_o  = out_q.flags;
  assign edge_total_o      = out_total_q;
  assign unshared_first_o  = out_q.uf;
  assign unshared_second_o = out_q.us;
  assign shared_first_o    = out_q.sf;
  assign shared_second_o   = out_q.ss;
  assign tri_first_o       = out_q.t1;
  assign tri_second_o      = out_q.t2;

endmodule

>>> hw/rtl/met_ram.sv
module met_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/met_quad.sv
module met_quad #(
  parameter int VB = 16
) (
  input  logic [VB-1:0] p1_i [3],
  input  logic [VB-1:0] p2_i [3],
  output logic          ok_o,
  output logic [VB-1:0] unshared_first_o,
  output logic [VB-1:0] unshared_second_o,
  output logic [VB-1:0] shared_first_o,
  output logic [VB-1:0] shared_second_o
);

  logic [2:0]    in_p2;
  logic          u_found;
  logic [1:0]    u;
  logic [VB-1:0] sf;
  logic [VB-1:0] ss;
  logic          o_found;
  logic [1:0]    o;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_p2[i] = (p1_i[i] == p2_i[0]) || (p1_i[i] == p2_i[1]) || (p1_i[i] == p2_i[2]);
    end
    u_found = 1'b1;
    if (!in_p2[0]) u = 2'd0;
    else if (!in_p2[1]) u = 2'd1;
    else if (!in_p2[2]) u = 2'd2;
    else begin
      u = 2'd0;
      u_found = 1'b0;
    end
    // Shared vertices follow the unshared one in reverse cyclic order of the first triangle.
    case (u)
      2'd0: begin sf = p1_i[2]; ss = p1_i[1]; end
      2'd1: begin sf = p1_i[0]; ss = p1_i[2]; end
      default: begin sf = p1_i[1]; ss = p1_i[0]; end
    endcase
    o_found = 1'b1;
    if (p2_i[0] != sf && p2_i[0] != ss) o = 2'd0;
    else if (p2_i[1] != sf && p2_i[1] != ss) o = 2'd1;
    else if (p2_i[2] != sf && p2_i[2] != ss) o = 2'd2;
    else begin
      o = 2'd0;
      o_found = 1'b0;
    end
  end

  assign ok_o              = u_found && o_found;
  assign unshared_first_o  = p1_i[u];
  assign unshared_second_o = p2_i[o];
  assign shared_first_o    = sf;
  assign shared_second_o   = ss;

endmodule

>>> hw/rtl/met_checker.sv
module met_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [2:0]  new_edge_flags_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("accepted item not in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)))
    else $error("stalled result changed");

  a_full_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != met_pkg::StatusOk) |-> new_edge_flags_o == 3'd0)
    else $error("new edges flagged on a failed item");

  a_no_result_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind mesh_edge_table_and_adjacent_pairs met_checker u_met_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .new_edge_flags_o
);
